[hw/rtl/atc_pkg.sv]
// Package for the ANSI text console: grid geometry, character codes,
// and the word types carried on the request and response channels. No dependencies.
`default_nettype none

package atc_pkg;

	localparam int COLS   = 30;
	localparam int ROWS   = 20;
	localparam int CELLS  = ROWS * COLS;
	localparam int COL_W  = 5;
	localparam int ROW_W  = 5;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CELL_W = 12;
	localparam int PAL_W  = 4;

	localparam logic [PAL_W-1:0]  PAL_RESET = 4'd15;
	localparam logic [CELL_W-1:0] BLANK     = 12'h020;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_ESC    = 8'h1b;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_2      = 8'h32;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UP     = 8'h41;
	localparam logic [7:0] CH_DOWN   = 8'h42;
	localparam logic [7:0] CH_RIGHT  = 8'h43;
	localparam logic [7:0] CH_LEFT   = 8'h44;
	localparam logic [7:0] CH_HOME   = 8'h48;
	localparam logic [7:0] CH_ERASE  = 8'h4a;
	localparam logic [7:0] CH_EOL    = 8'h4b;
	localparam logic [7:0] CH_POS_F  = 8'h66;
	localparam logic [7:0] CH_SAVE   = 8'h73;
	localparam logic [7:0] CH_REST   = 8'h75;
	localparam logic [7:0] CH_NL_LO  = 8'd10;
	localparam logic [7:0] CH_NL_HI  = 8'd13;

	typedef struct packed {
		logic             func;
		logic [7:0]       byte_req;
		logic             last_in_write;
		logic [ROW_W-1:0] read_row;
		logic [COL_W-1:0] read_col;
	} req_word_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_value;
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
	} rsp_word_t;

endpackage

`default_nettype wire

[hw/rtl/atc_if.sv]
// Valid/ready channel interfaces for the ANSI text console.
// Depends on atc_pkg for the word types.
`default_nettype none

interface atc_req_if;
	logic              valid;
	logic              ready;
	atc_pkg::req_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface atc_rsp_if;
	logic              valid;
	logic              ready;
	atc_pkg::rsp_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/ansi_text_console.sv]
// ANSI text console top level: escape parser, cursor, and the character grid memory.
// Depends on atc_pkg and the channel interfaces in atc_if.sv.
`default_nettype none

// Channel  | Dir | Word                                      | Handshake
// req      | in  | func, byte_req, last_in_write, row, col   | valid/ready
// rsp      | out | cell_value, cursor_col, cursor_row        | valid/ready
// cfg      | in  | text_palette (4 bits)                     | write enable only
//
// The single write port of the grid memory sets the long cases: a scroll clears the
// new bottom row at one cell per cycle, and both reset and ESC[2J run a clearing
// pass over all 600 cells, during which req.ready stays low. The response sits in
// an output register, so the next word is taken while the previous response waits;
// a stalled rsp holds only the final step of the next word.

module ansi_text_console (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [atc_pkg::PAL_W-1:0] cfg_wdata,
	atc_req_if.sink                      req,
	atc_rsp_if.source                    rsp
);
	import atc_pkg::*;

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_CMD, S_RD, S_PRINT, S_SCR, S_FIN
	} state_t;

	state_t            state_q;
	logic [PAL_W-1:0]  palette_q;
	logic [COL_W-1:0]  cur_col_q, saved_col_q, scr_col_q;
	logic [ROW_W-1:0]  cur_row_q, saved_row_q, base_q, scr_row_q;
	logic [1:0]        phase_q, have_q;
	logic [7:0]        num1_q, num2_q, glyph_q, pend_glyph_q;
	logic              slot_q, two_q, pend_q, ret_fin_q, clr_boot_q, out_valid_q;
	logic [ADDR_W-1:0] clr_ptr_q;
	req_word_t         item_q;
	logic [CELL_W-1:0] cell_q, rdata_q;
	rsp_word_t         out_q;

	logic [CELL_W-1:0] mem [CELLS];

	// Rows are kept in a ring: base_q is the physical row that shows as row 0,
	// so a scroll only moves base_q and blanks one row.
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [ROW_W-1:0] base);
		logic [ROW_W:0] sum;
		logic [ROW_W:0] phys;
		sum  = {1'b0, row} + {1'b0, base};
		phys = (sum >= (ROW_W+1)'(ROWS)) ? sum - (ROW_W+1)'(ROWS) : sum;
		return ADDR_W'(ADDR_W'(phys) * ADDR_W'(COLS) + ADDR_W'(col));
	endfunction

	logic [7:0]        c;
	logic              is_digit, seq_end, newline, rd_ok;
	logic [7:0]        n, num_sel, sat;
	logic [11:0]       prod;
	logic [8:0]        row_sum, col_sum;
	logic [ADDR_W-1:0] rd_addr, mem_wa;
	logic              mem_we;
	logic [CELL_W-1:0] mem_wd;

	always_comb begin
		c        = item_q.byte_req;
		is_digit = (c >= CH_0) && (c <= CH_9);
		seq_end  = c inside {CH_HOME, CH_POS_F, CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT,
			CH_EOL, CH_SAVE, CH_REST, CH_ERASE};
		n        = have_q[0] ? num1_q : 8'd1;
		num_sel  = slot_q ? num2_q : num1_q;
		prod     = {4'b0, num_sel} * 12'd10 + {4'b0, c - CH_0};
		sat      = (prod > 12'd255) ? 8'd255 : prod[7:0];
		row_sum  = {4'b0, cur_row_q} + {1'b0, n};
		col_sum  = {4'b0, cur_col_q} + {1'b0, n};
		newline  = (glyph_q >= CH_NL_LO) && (glyph_q <= CH_NL_HI);
		rd_ok    = (item_q.read_row < ROW_W'(ROWS)) && (item_q.read_col < COL_W'(COLS));
		rd_addr  = rd_ok ? cell_addr(item_q.read_row, item_q.read_col, base_q) : '0;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cell_addr(cur_row_q, cur_col_q, base_q);
		mem_wd = {palette_q, glyph_q};
		case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				mem_wa = clr_ptr_q;
				mem_wd = BLANK;
			end
			S_SCR: begin
				mem_we = 1'b1;
				mem_wa = cell_addr(scr_row_q, scr_col_q, '0);
				mem_wd = BLANK;
			end
			S_PRINT: begin
				mem_we = (cur_col_q < COL_W'(COLS)) && !newline;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_boot_q   <= 1'b1;
			clr_ptr_q    <= '0;
			palette_q    <= PAL_RESET;
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			saved_col_q  <= '0;
			saved_row_q  <= '0;
			base_q       <= '0;
			phase_q      <= '0;
			have_q       <= '0;
			num1_q       <= '0;
			num2_q       <= '0;
			slot_q       <= 1'b0;
			two_q        <= 1'b0;
			pend_q       <= 1'b0;
			pend_glyph_q <= '0;
			glyph_q      <= '0;
			ret_fin_q    <= 1'b0;
			scr_col_q    <= '0;
			scr_row_q    <= '0;
			item_q       <= '0;
			cell_q       <= '0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				palette_q <= cfg_wdata;
			end
			// In S_FIN the output register is reloaded instead of emptied.
			if (out_valid_q && rsp.ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					if (clr_ptr_q == ADDR_W'(CELLS - 1)) begin
						clr_ptr_q  <= '0;
						clr_boot_q <= 1'b0;
						state_q    <= clr_boot_q ? S_IDLE : S_FIN;
					end else begin
						clr_ptr_q <= clr_ptr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						item_q  <= req.data;
						state_q <= S_CMD;
					end
				end
				S_CMD: begin
					cell_q  <= '0;
					state_q <= S_FIN;
					if (item_q.func) begin
						state_q <= S_RD;
					end else if (phase_q == 2'd2) begin
						if (c != CH_NUL) begin
							two_q <= (c == CH_2);
							if (is_digit) begin
								if (slot_q) num2_q <= sat;
								else        num1_q <= sat;
								if (!slot_q)        have_q[0] <= 1'b1;
								else if (have_q[0]) have_q[1] <= 1'b1;
							end else begin
								case (c)
									CH_SEMI: slot_q <= 1'b1;
									CH_HOME, CH_POS_F: begin
										if (have_q[0]) begin
											cur_row_q <= (num1_q > 8'(ROWS - 1)) ?
												ROW_W'(ROWS - 1) : num1_q[ROW_W-1:0];
										end
										if (have_q[1]) begin
											cur_col_q <= (num2_q > 8'(COLS - 1)) ?
												COL_W'(COLS - 1) : num2_q[COL_W-1:0];
										end
									end
									CH_UP: cur_row_q <= ({3'b0, cur_row_q} < n) ? '0 :
										ROW_W'({3'b0, cur_row_q} - n);
									CH_DOWN: cur_row_q <= (row_sum > 9'(ROWS - 1)) ?
										ROW_W'(ROWS - 1) : row_sum[ROW_W-1:0];
									CH_RIGHT: cur_col_q <= (col_sum > 9'(COLS - 1)) ?
										COL_W'(COLS - 1) : col_sum[COL_W-1:0];
									CH_LEFT: cur_col_q <= ({3'b0, cur_col_q} < n) ? '0 :
										COL_W'({3'b0, cur_col_q} - n);
									CH_SAVE: begin
										saved_col_q <= cur_col_q;
										saved_row_q <= cur_row_q;
									end
									CH_REST: begin
										cur_col_q <= saved_col_q;
										cur_row_q <= saved_row_q;
									end
									CH_ERASE: begin
										if (two_q) begin
											cur_col_q <= '0;
											cur_row_q <= '0;
											state_q   <= S_CLR;
										end
									end
									default: ;
								endcase
								if (seq_end) begin
									phase_q <= 2'd0;
									two_q   <= 1'b0;
								end
							end
						end
					end else if (phase_q == 2'd1) begin
						phase_q <= 2'd0;
						if (c == CH_LBRACK) begin
							phase_q <= 2'd2;
							num1_q  <= '0;
							num2_q  <= '0;
							slot_q  <= 1'b0;
							have_q  <= '0;
							two_q   <= 1'b0;
						end else begin
							// The waiting ESC prints first, then this byte as plain text.
							glyph_q      <= CH_ESC;
							state_q      <= S_PRINT;
							pend_glyph_q <= c;
							pend_q       <= (c != CH_NUL) &&
								((c != CH_ESC) || item_q.last_in_write);
							if ((c == CH_ESC) && !item_q.last_in_write) begin
								phase_q <= 2'd1;
							end
						end
					end else begin
						if (c == CH_ESC) begin
							if (item_q.last_in_write) begin
								glyph_q <= CH_ESC;
								state_q <= S_PRINT;
							end else begin
								phase_q <= 2'd1;
							end
						end else if (c != CH_NUL) begin
							glyph_q <= c;
							state_q <= S_PRINT;
						end
					end
				end
				S_RD: begin
					cell_q  <= rd_ok ? rdata_q : '0;
					state_q <= S_FIN;
				end
				S_PRINT: begin
					if (cur_col_q >= COL_W'(COLS)) begin
						// Pending wrap: move to the next line, then print on it.
						cur_col_q <= '0;
						if (cur_row_q < ROW_W'(ROWS - 1)) begin
							cur_row_q <= cur_row_q + 1'b1;
						end else begin
							ret_fin_q <= 1'b0;
							scr_row_q <= base_q;
							scr_col_q <= '0;
							base_q    <= (base_q == ROW_W'(ROWS - 1)) ? '0 : base_q + 1'b1;
							state_q   <= S_SCR;
						end
					end else if (newline) begin
						cur_col_q <= '0;
						if (cur_row_q < ROW_W'(ROWS - 1)) begin
							cur_row_q <= cur_row_q + 1'b1;
							if (pend_q) begin
								glyph_q <= pend_glyph_q;
								pend_q  <= 1'b0;
							end else begin
								state_q <= S_FIN;
							end
						end else begin
							ret_fin_q <= 1'b1;
							scr_row_q <= base_q;
							scr_col_q <= '0;
							base_q    <= (base_q == ROW_W'(ROWS - 1)) ? '0 : base_q + 1'b1;
							state_q   <= S_SCR;
						end
					end else begin
						cur_col_q <= cur_col_q + 1'b1;
						if (pend_q) begin
							glyph_q <= pend_glyph_q;
							pend_q  <= 1'b0;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCR: begin
					// Blank the row that used to be on top; it is now the bottom row.
					if (scr_col_q == COL_W'(COLS - 1)) begin
						if (!ret_fin_q) begin
							state_q <= S_PRINT;
						end else if (pend_q) begin
							glyph_q <= pend_glyph_q;
							pend_q  <= 1'b0;
							state_q <= S_PRINT;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						scr_col_q <= scr_col_q + 1'b1;
					end
				end
				S_FIN: begin
					if (!out_valid_q || rsp.ready) begin
						out_q.cell_value <= cell_q;
						out_q.cursor_col <= cur_col_q;
						out_q.cursor_row <= cur_row_q;
						out_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

`ifndef SYNTHESIS
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_row_q < ROW_W'(ROWS)) else $error("cursor row out of grid");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_col_q <= COL_W'(COLS)) else $error("cursor column beyond wrap point");
	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		base_q < ROW_W'(ROWS)) else $error("ring base out of range");
	a_waddr: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (mem_wa < ADDR_W'(CELLS))) else $error("grid write out of range");
	a_clr_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !req.ready) else $error("word taken during clear");
`endif

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for ansi_text_console: drives console and read words over the
// valid/ready request channel, predicts grid and cursor, and checks every response word.
// Depends on atc_pkg and the channel interfaces in atc_if.sv.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import atc_pkg::*;

	// Escape parser phases of the predictor.
	typedef enum int {PH_TEXT, PH_ESC, PH_SEQ} esc_phase_t;

	// One row of the directed stimulus. When has_exp is set, the response is typed in
	// here; otherwise the predictor supplies it.
	typedef struct {
		bit          func;
		logic [7:0]  ch;
		bit          last;
		logic [4:0]  row;
		logic [4:0]  col;
		bit          has_exp;
		logic [11:0] ecell;
		logic [4:0]  ecol;
		logic [4:0]  erow;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [PAL_W-1:0] cfg_wdata;

	atc_req_if req ();
	atc_rsp_if rsp ();

	ansi_text_console u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.rsp      (rsp)
	);

	// Predictor state: a private copy of the grid, cursor, parser, and palette.
	logic [CELL_W-1:0] screen [CELLS];
	int         cur_c, cur_r, save_c, save_r;
	esc_phase_t phase;
	int         num0, num1;
	bit         slot;
	bit [1:0]   seen;
	bit         last_two;
	logic [PAL_W-1:0] palette;

	// Responses still owed by the block, oldest first.
	rsp_word_t  owed_rsp [$];
	int         errors;
	int         words_sent;
	int         reads_sent;
	int         seqs_sent;
	int         clears_sent;
	int         words_checked;
	bit         rsp_calm;

	// The clock runs at 10 ns.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Everything is driven to a known value from time zero.
	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.data  = '0;
		rsp.ready = 1'b0;
	end

	// A hard limit far above the slowest legal run.
	initial begin
		#40ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d (word %0d)", what, got, want, words_checked);
		errors++;
	endtask

	// A new line: move down one row, and scroll the whole grid up when the bottom
	// row is left. The new bottom row is blank.
	task automatic line_feed();
		cur_r++;
		if (cur_r >= ROWS) begin
			cur_r = ROWS - 1;
			for (int i = 0; i < (ROWS - 1) * COLS; i++)
				screen[i] = screen[i + COLS];
			for (int i = (ROWS - 1) * COLS; i < CELLS; i++)
				screen[i] = BLANK;
		end
	endtask

	// Printing first resolves a pending wrap, then either stores the glyph with the
	// current palette or, for codes 10 to 13, starts a new line.
	task automatic put_glyph(input logic [7:0] c);
		if (cur_c >= COLS) begin
			cur_c = 0;
			line_feed();
		end
		if (c >= CH_NL_LO && c <= CH_NL_HI) begin
			line_feed();
			cur_c = 0;
		end else begin
			screen[cur_r * COLS + cur_c] = {palette, c};
			cur_c++;
		end
	endtask

	// Plain text: NUL is dropped, an ESC either waits for a bracket or, at the end of
	// a write, prints at once.
	task automatic plain_text(input logic [7:0] c, input bit last);
		if (c == CH_NUL)
			return;
		if (c == CH_ESC) begin
			if (last)
				put_glyph(CH_ESC);
			else
				phase = PH_ESC;
			return;
		end
		put_glyph(c);
	endtask

	// Work out the response that one accepted request word causes.
	task automatic predict_console(input req_word_t w, output rsp_word_t r);
		logic [11:0] cell_v;
		logic [7:0]  c;
		int          n;
		bit          was_two;
		bit          done;
		cell_v = '0;
		c      = w.byte_req;
		if (w.func) begin
			if (w.read_row < ROWS && w.read_col < COLS)
				cell_v = screen[w.read_row * COLS + w.read_col];
		end else if (phase == PH_SEQ) begin
			if (c != CH_NUL) begin
				n        = seen[0] ? num0 : 1;
				was_two  = last_two;
				last_two = (c == CH_2);
				done     = 1'b1;
				if (c >= CH_0 && c <= CH_9) begin
					// Digits build the current number, saturating at 255.
					if (slot) begin
						num1 = num1 * 10 + (c - CH_0);
						if (num1 > 255) num1 = 255;
						if (seen[0]) seen[1] = 1'b1;
					end else begin
						num0 = num0 * 10 + (c - CH_0);
						if (num0 > 255) num0 = 255;
						seen[0] = 1'b1;
					end
					done = 1'b0;
				end else begin
					case (c)
						CH_SEMI: begin
							slot = 1'b1;
							done = 1'b0;
						end
						CH_HOME, CH_POS_F: begin
							if (seen[0]) cur_r = (num0 > ROWS - 1) ? ROWS - 1 : num0;
							if (seen[1]) cur_c = (num1 > COLS - 1) ? COLS - 1 : num1;
						end
						CH_UP:    cur_r = (cur_r < n) ? 0 : cur_r - n;
						CH_DOWN:  cur_r = (cur_r + n > ROWS - 1) ? ROWS - 1 : cur_r + n;
						CH_RIGHT: cur_c = (cur_c + n > COLS - 1) ? COLS - 1 : cur_c + n;
						CH_LEFT:  cur_c = (cur_c < n) ? 0 : cur_c - n;
						CH_EOL: ;
						CH_SAVE: begin
							save_c = cur_c;
							save_r = cur_r;
						end
						CH_REST: begin
							cur_c = save_c;
							cur_r = save_r;
						end
						CH_ERASE: begin
							// Only ESC[2J clears; any other J just ends the sequence.
							if (was_two) begin
								for (int i = 0; i < CELLS; i++)
									screen[i] = BLANK;
								cur_c = 0;
								cur_r = 0;
							end
						end
						default: done = 1'b0;
					endcase
				end
				if (done) begin
					phase    = PH_TEXT;
					last_two = 1'b0;
				end
			end
		end else if (phase == PH_ESC) begin
			phase = PH_TEXT;
			if (c == CH_LBRACK) begin
				phase    = PH_SEQ;
				num0     = 0;
				num1     = 0;
				slot     = 1'b0;
				seen     = '0;
				last_two = 1'b0;
			end else begin
				// A lone ESC prints as a glyph, and the byte is then plain text.
				put_glyph(CH_ESC);
				plain_text(c, w.last_in_write);
			end
		end else begin
			plain_text(c, w.last_in_write);
		end
		r.cell_value = cell_v;
		r.cursor_col = cur_c[4:0];
		r.cursor_row = cur_r[4:0];
	endtask

	// Present one word, wait for it to be taken, and record what it must produce.
	// The gap before it is random, mostly short and now and then long.
	task automatic send_word(input req_word_t w, input bit has_exp, input rsp_word_t exp_rsp);
		int        gap;
		rsp_word_t r;
		gap = ($urandom_range(0, 9) < 6) ? 0 :
		      ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
		if (gap > 0) begin
			@(negedge clk);
			req.valid <= 1'b0;
			req.data  <= '0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req.valid <= 1'b1;
		req.data  <= w;
		do @(posedge clk); while (!req.ready);
		predict_console(w, r);
		owed_rsp.push_back(has_exp ? exp_rsp : r);
		words_sent++;
		if (w.func) reads_sent++;
	endtask

	task automatic send_byte(input logic [7:0] c, input bit last);
		req_word_t w;
		w.func          = 1'b0;
		w.byte_req      = c;
		w.last_in_write = last;
		w.read_row      = 5'($urandom_range(0, 31));
		w.read_col      = 5'($urandom_range(0, 31));
		send_word(w, 1'b0, '0);
	endtask

	task automatic send_read();
		req_word_t w;
		w.func          = 1'b1;
		w.byte_req      = 8'($urandom_range(0, 255));
		w.last_in_write = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) < 8) begin
			w.read_row = 5'($urandom_range(0, ROWS - 1));
			w.read_col = 5'($urandom_range(0, COLS - 1));
		end else begin
			w.read_row = 5'($urandom_range(0, 31));
			w.read_col = 5'($urandom_range(0, 31));
		end
		send_word(w, 1'b0, '0);
	endtask

	// Random last flag: most bytes are in the middle of a write.
	function automatic bit rand_last();
		return ($urandom_range(0, 5) == 0);
	endfunction

	// A decimal number of zero to three digits, as it would appear in a sequence.
	task automatic send_digits();
		int count;
		count = $urandom_range(0, 3);
		repeat (count) send_byte(CH_0 + 8'($urandom_range(0, 9)), rand_last());
	endtask

	// A mostly well-formed control sequence with random numbers; now and then a
	// stray byte or NUL lands inside it.
	task automatic send_sequence();
		logic [7:0] finals [10];
		logic [7:0] fin;
		finals = '{CH_HOME, CH_POS_F, CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT,
		           CH_EOL, CH_SAVE, CH_REST, CH_ERASE};
		send_byte(CH_ESC, 1'b0);
		send_byte(CH_LBRACK, rand_last());
		if ($urandom_range(0, 9) == 0)
			send_byte(CH_NUL, rand_last());
		send_digits();
		if ($urandom_range(0, 2) != 0) begin
			send_byte(CH_SEMI, rand_last());
			send_digits();
		end
		if ($urandom_range(0, 9) == 0)
			send_byte(8'($urandom_range(0, 255)), rand_last());
		fin = finals[$urandom_range(0, 9)];
		if (fin == CH_ERASE && $urandom_range(0, 1)) begin
			send_byte(CH_2, rand_last());
			clears_sent++;
		end
		send_byte(fin, rand_last());
		seqs_sent++;
	endtask

	// One random stretch of traffic of about the given number of words.
	task automatic run_random(input int count);
		int stop_at;
		int pick;
		stop_at = words_sent + count;
		while (words_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				send_byte(8'($urandom_range(32, 126)), rand_last());
			else if (pick < 42)
				send_byte(CH_NL_LO + 8'($urandom_range(0, 3)), rand_last());
			else if (pick < 48)
				send_byte(8'($urandom_range(0, 255)), rand_last());
			else if (pick < 50)
				send_byte(CH_NUL, rand_last());
			else if (pick < 53) begin
				// A lone ESC followed by something other than a bracket.
				send_byte(CH_ESC, rand_last());
				send_byte(8'($urandom_range(32, 90)), rand_last());
			end else if (pick < 72)
				send_read();
			else
				send_sequence();
		end
	endtask

	// Wait until every owed response has come back, then give any clearing pass
	// time to finish before the palette may be touched.
	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		req.data  <= '0;
		while (owed_rsp.size() != 0) @(negedge clk);
		repeat (700) @(negedge clk);
	endtask

	task automatic write_palette(input logic [PAL_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		palette = v;
	endtask

	// Response side: the receiver stalls in random bursts, with calm stretches in
	// which it never stalls.
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (rsp_calm || $urandom_range(0, 9) < 7) begin
				rsp.ready <= 1'b1;
				hold = $urandom_range(0, 6);
			end else begin
				rsp.ready <= 1'b0;
				hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) :
				       $urandom_range(10, 40);
			end
		end
	end

	// Every accepted response word is checked against the oldest owed one.
	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (owed_rsp.size() == 0) begin
				report("words owed", 1, 0);
			end else begin
				want = owed_rsp.pop_front();
				if (rsp.data.cell_value !== want.cell_value)
					report("cell_value", rsp.data.cell_value, want.cell_value);
				if (rsp.data.cursor_col !== want.cursor_col)
					report("cursor_col", rsp.data.cursor_col, want.cursor_col);
				if (rsp.data.cursor_row !== want.cursor_row)
					report("cursor_row", rsp.data.cursor_row, want.cursor_row);
			end
			words_checked++;
		end
	end

	// Directed part: the blank grid after reset, an out-of-range read, NUL, a lone
	// ESC both at the end of a write and before a plain byte, saturating and clamped
	// H positions, a pending wrap resolved by a new line, a cursor save, a missing
	// count, a stray byte in a sequence, and ESC[2J.
	dir_row_t dir_rows [] = '{
		'{1, 8'h00,    0, 0,  0,  1, BLANK, 0,  0},
		'{1, 8'h00,    0, 31, 31, 1, 0,     0,  0},
		'{0, 8'h41,    1, 0,  0,  1, 0,     1,  0},
		'{0, CH_NUL,   0, 0,  0,  1, 0,     1,  0},
		'{0, CH_ESC,   1, 0,  0,  1, 0,     2,  0},
		'{0, CH_ESC,   0, 0,  0,  1, 0,     2,  0},
		'{0, 8'h78,    0, 0,  0,  1, 0,     4,  0},
		'{1, 8'h00,    0, 0,  2,  0, 0,     0,  0},
		'{0, CH_ESC,   0, 0,  0,  0, 0,     0,  0},
		'{0, CH_LBRACK,0, 0,  0,  0, 0,     0,  0},
		'{0, 8'h39,    0, 0,  0,  0, 0,     0,  0},
		'{0, CH_SEMI,  0, 0,  0,  0, 0,     0,  0},
		'{0, 8'h39,    0, 0,  0,  0, 0,     0,  0},
		'{0, 8'h39,    1, 0,  0,  0, 0,     0,  0},
		'{0, 8'h39,    0, 0,  0,  0, 0,     0,  0},
		'{0, CH_HOME,  0, 0,  0,  1, 0,     29, 9},
		'{0, 8'hff,    0, 0,  0,  1, 0,     30, 9},
		'{0, CH_NL_HI, 0, 0,  0,  0, 0,     0,  0},
		'{0, CH_ESC,   0, 0,  0,  0, 0,     0,  0},
		'{0, CH_LBRACK,0, 0,  0,  0, 0,     0,  0},
		'{0, CH_SAVE,  0, 0,  0,  0, 0,     0,  0},
		'{0, CH_ESC,   0, 0,  0,  0, 0,     0,  0},
		'{0, CH_LBRACK,0, 0,  0,  0, 0,     0,  0},
		'{0, 8'h2d,    0, 0,  0,  0, 0,     0,  0},
		'{0, CH_UP,    0, 0,  0,  0, 0,     0,  0},
		'{0, CH_ESC,   0, 0,  0,  0, 0,     0,  0},
		'{0, CH_LBRACK,0, 0,  0,  0, 0,     0,  0},
		'{0, CH_2,     0, 0,  0,  0, 0,     0,  0},
		'{0, CH_ERASE, 0, 0,  0,  1, 0,     0,  0}
	};

	initial begin
		req_word_t w;
		rsp_word_t e;
		errors        = 0;
		words_sent    = 0;
		reads_sent    = 0;
		seqs_sent     = 0;
		clears_sent   = 0;
		words_checked = 0;
		rsp_calm      = 1'b0;

		// Predictor reset state.
		for (int i = 0; i < CELLS; i++)
			screen[i] = BLANK;
		cur_c    = 0;
		cur_r    = 0;
		save_c   = 0;
		save_r   = 0;
		phase    = PH_TEXT;
		num0     = 0;
		num1     = 0;
		slot     = 1'b0;
		seen     = '0;
		last_two = 1'b0;
		palette  = PAL_RESET;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed words run with the reset palette.
		foreach (dir_rows[i]) begin
			w.func          = dir_rows[i].func;
			w.byte_req      = dir_rows[i].ch;
			w.last_in_write = dir_rows[i].last;
			w.read_row      = dir_rows[i].row;
			w.read_col      = dir_rows[i].col;
			e.cell_value    = dir_rows[i].ecell;
			e.cursor_col    = dir_rows[i].ecol;
			e.cursor_row    = dir_rows[i].erow;
			send_word(w, dir_rows[i].has_exp, e);
		end
		drain();

		// Random phases, each under its own palette, both extremes included.
		write_palette('0);
		run_random(250);
		drain();
		write_palette(4'hf);
		rsp_calm = 1'b1;
		run_random(250);
		drain();
		rsp_calm = 1'b0;
		write_palette(PAL_W'($urandom_range(1, 14)));
		run_random(250);
		drain();

		$display("covered %0d words: %0d cell reads, %0d control sequences, %0d screen clears",
		         words_sent, reads_sent, seqs_sent, clears_sent);
		$display("palette settings used: reset value, 0, 15 and one in between");
		if (errors == 0 && owed_rsp.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
hw/rtl/atc_pkg.sv
hw/rtl/atc_if.sv
hw/rtl/ansi_text_console.sv
bench/tb.sv
